// ----- src/tcsg_pkg.sv -----
// Shared types and constants for the thick circle span generator.
`default_nettype none

package tcsg_pkg;

    // Input item kind carried on s_axis_tuser
    typedef enum logic {
        MODE_START = 1'b0,
        MODE_STEP  = 1'b1
    } mode_t;

    // Span counter within one row
    typedef logic [2:0] span_idx_t;
    localparam span_idx_t SPAN_IDX_FIRST = 3'd0;
    localparam span_idx_t SPAN_IDX_LAST  = 3'd7;

    // Result tuser bit positions
    localparam int OUT_USER_VERT = 0;
    localparam int OUT_USER_DONE = 1;
    localparam int OUT_USER_BITS = 2;

endpackage : tcsg_pkg

`default_nettype wire

// ----- src/thick_circle_span_generator.sv -----
// Top level of the thick circle span generator: ring state, span sequencer, result register.
`default_nettype none

// Rasterizes a ring between an inner and an outer radius with two coupled
// midpoint-circle error terms. A start item (tuser = 0) loads center, radii
// and color and returns nothing. A step item (tuser = 1) returns the eight
// octant spans of the current row, one per cycle while m_axis_tready allows,
// the last one flagged by m_axis_tlast, then advances the row; once the ring is
// finished a step returns a single done item instead. The one-span-per-cycle
// sequencer sets the rate: the next item is taken in the cycle the last span
// of a step enters the result register, so steps run back to back while
// m_axis_tready stays high. An inner radius above the outer one is
// clamped to the outer radius; a span whose start exceeds its end draws
// nothing but is still returned.
module thick_circle_span_generator
    import tcsg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24,
    localparam int SPAN_BITS     = COORD_BITS + 2,
    localparam int RAD_BITS      = COORD_BITS - 1,
    localparam int IN_RAW_BITS   = 2 * COORD_BITS + 2 * RAD_BITS + COLOR_BITS,
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8,
    localparam int OUT_RAW_BITS  = 3 * SPAN_BITS + COLOR_BITS,
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    // item in
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    // center_x, center_y, outer_radius, inner_radius, color, zero pad
    input  wire  [IN_DATA_BITS-1:0] s_axis_tdata,
    // mode
    input  wire  [0:0]              s_axis_tuser,
    // item out
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    // fixed_coord, span_start, span_end, span_color, zero pad
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // span_vertical, done_res
    output logic [OUT_USER_BITS-1:0] m_axis_tuser,
    output logic                    m_axis_tlast
);

    localparam int CX_LO  = 0;
    localparam int CY_LO  = CX_LO + COORD_BITS;
    localparam int RO_LO  = CY_LO + COORD_BITS;
    localparam int RI_LO  = RO_LO + RAD_BITS;
    localparam int COL_LO = RI_LO + RAD_BITS;

    // ring state
    logic        [COORD_BITS-1:0] center_col_reg,  center_col_next;
    logic        [COORD_BITS-1:0] center_row_reg,  center_row_next;
    logic signed [COORD_BITS-1:0] outer_x_reg,     outer_x_next;
    logic        [COORD_BITS-1:0] inner_x_reg,     inner_x_next;
    logic        [COORD_BITS-1:0] inner_limit_reg, inner_limit_next;
    logic        [COORD_BITS-1:0] row_offset_reg,  row_offset_next;
    logic signed [SPAN_BITS-1:0]  outer_error_reg, outer_error_next;
    logic signed [SPAN_BITS-1:0]  inner_error_reg, inner_error_next;
    logic        [COLOR_BITS-1:0] ring_color_reg,  ring_color_next;

    // sequencer
    logic      job_active_reg, job_active_next;
    span_idx_t job_idx_reg,    job_idx_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic                        out_vert_reg,  out_vert_next;
    logic                        out_done_reg,  out_done_next;
    logic                        out_last_reg,  out_last_next;
    logic signed [SPAN_BITS-1:0] out_fixed_reg, out_fixed_next;
    logic signed [SPAN_BITS-1:0] out_start_reg, out_start_next;
    logic signed [SPAN_BITS-1:0] out_end_reg,   out_end_next;
    logic [COLOR_BITS-1:0]       out_color_reg, out_color_next;

    logic in_accept;
    logic out_load;
    logic ring_done;
    logic job_finish;
    mode_t in_mode;

    // start item fields
    logic [RAD_BITS-1:0] in_ro;
    logic [RAD_BITS-1:0] in_ri;
    logic [RAD_BITS-1:0] in_ri_sat;

    // row advance
    logic        [COORD_BITS-1:0] y_inc;
    logic signed [COORD_BITS-1:0] x0_dec;
    logic        [COORD_BITS-1:0] xi_dec;
    logic signed [SPAN_BITS-1:0]  y_inc_e;

    // span arithmetic operands
    logic signed [SPAN_BITS-1:0] cx_e, cy_e, x0_e, xi_e, y_e;
    logic signed [SPAN_BITS-1:0] span_fixed, span_start, span_end;

    assign in_mode   = mode_t'(s_axis_tuser[0]);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign ring_done = $signed({outer_x_reg[COORD_BITS-1], outer_x_reg})
                       < $signed({1'b0, row_offset_reg});

    // sequencer hands one span to the result register when it is free
    assign out_load   = job_active_reg && (!out_valid_reg || m_axis_tready);
    assign job_finish = out_load && (ring_done || job_idx_reg == SPAN_IDX_LAST);
    assign s_axis_tready = !job_active_reg || job_finish;

    // start item decode, inner radius clamped to outer
    assign in_ro     = s_axis_tdata[RO_LO +: RAD_BITS];
    assign in_ri     = s_axis_tdata[RI_LO +: RAD_BITS];
    assign in_ri_sat = (in_ri > in_ro) ? in_ro : in_ri;

    // operands widened to span width
    assign cx_e    = $signed({2'b00, center_col_reg});
    assign cy_e    = $signed({2'b00, center_row_reg});
    assign x0_e    = SPAN_BITS'(outer_x_reg);
    assign xi_e    = $signed({2'b00, inner_x_reg});
    assign y_e     = $signed({2'b00, row_offset_reg});
    assign y_inc   = row_offset_reg + COORD_BITS'(1);
    assign y_inc_e = $signed({2'b00, y_inc});
    assign x0_dec  = outer_x_reg - COORD_BITS'(1);
    assign xi_dec  = inner_x_reg - COORD_BITS'(1);

    // octant span for the current counter value
    always_comb begin
        case (job_idx_reg)
            3'd0: begin
                span_fixed = cy_e + y_e;  span_start = cx_e + xi_e;  span_end = cx_e + x0_e;
            end
            3'd1: begin
                span_fixed = cx_e + y_e;  span_start = cy_e + xi_e;  span_end = cy_e + x0_e;
            end
            3'd2: begin
                span_fixed = cy_e + y_e;  span_start = cx_e - x0_e;  span_end = cx_e - xi_e;
            end
            3'd3: begin
                span_fixed = cx_e - y_e;  span_start = cy_e + xi_e;  span_end = cy_e + x0_e;
            end
            3'd4: begin
                span_fixed = cy_e - y_e;  span_start = cx_e - x0_e;  span_end = cx_e - xi_e;
            end
            3'd5: begin
                span_fixed = cx_e - y_e;  span_start = cy_e - x0_e;  span_end = cy_e - xi_e;
            end
            3'd6: begin
                span_fixed = cy_e - y_e;  span_start = cx_e + xi_e;  span_end = cx_e + x0_e;
            end
            3'd7: begin
                span_fixed = cx_e + y_e;  span_start = cy_e - x0_e;  span_end = cy_e - xi_e;
            end
            default: begin
                span_fixed = '0;  span_start = '0;  span_end = '0;
            end
        endcase
    end

    // ring state: start load wins over the row advance of a finishing step
    always_comb begin
        center_col_next  = center_col_reg;
        center_row_next  = center_row_reg;
        outer_x_next     = outer_x_reg;
        inner_x_next     = inner_x_reg;
        inner_limit_next = inner_limit_reg;
        row_offset_next  = row_offset_reg;
        outer_error_next = outer_error_reg;
        inner_error_next = inner_error_reg;
        ring_color_next  = ring_color_reg;

        if (in_accept && in_mode == MODE_START) begin
            center_col_next  = s_axis_tdata[CX_LO +: COORD_BITS];
            center_row_next  = s_axis_tdata[CY_LO +: COORD_BITS];
            outer_x_next     = $signed({1'b0, in_ro});
            inner_x_next     = {1'b0, in_ri_sat};
            inner_limit_next = {1'b0, in_ri_sat};
            row_offset_next  = '0;
            outer_error_next = $signed(SPAN_BITS'(1) - SPAN_BITS'(in_ro));
            inner_error_next = $signed(SPAN_BITS'(1) - SPAN_BITS'(in_ri_sat));
            ring_color_next  = s_axis_tdata[COL_LO +: COLOR_BITS];
        end else if (out_load && !ring_done && job_idx_reg == SPAN_IDX_LAST) begin
            row_offset_next = y_inc;
            // outer midpoint step
            if (outer_error_reg < 0) begin
                outer_error_next = outer_error_reg + {y_inc_e[SPAN_BITS-2:0], 1'b1};
            end else begin
                outer_x_next     = x0_dec;
                outer_error_next = outer_error_reg
                                   + ((y_inc_e - SPAN_BITS'(x0_dec) + SPAN_BITS'(1)) <<< 1);
            end
            // inner midpoint step; once the row passes the inner radius the inner edge tracks the row
            if (y_inc > inner_limit_reg) begin
                inner_x_next = y_inc;
            end else if (inner_error_reg < 0) begin
                inner_error_next = inner_error_reg + {y_inc_e[SPAN_BITS-2:0], 1'b1};
            end else begin
                inner_x_next     = xi_dec;
                inner_error_next = inner_error_reg
                                   + ((y_inc_e - $signed({2'b00, xi_dec}) + SPAN_BITS'(1)) <<< 1);
            end
        end
    end

    // sequencer
    always_comb begin
        job_active_next = job_active_reg;
        job_idx_next    = job_idx_reg;
        if (out_load) begin
            job_idx_next = job_idx_reg + 3'd1;
        end
        if (job_finish) begin
            job_active_next = 1'b0;
        end
        if (in_accept && in_mode == MODE_STEP) begin
            job_active_next = 1'b1;
            job_idx_next    = SPAN_IDX_FIRST;
        end
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_vert_next  = out_vert_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;
        out_fixed_next = out_fixed_reg;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_color_next = out_color_reg;
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
            if (ring_done) begin
                out_vert_next  = 1'b0;
                out_done_next  = 1'b1;
                out_last_next  = 1'b1;
                out_fixed_next = '0;
                out_start_next = '0;
                out_end_next   = '0;
                out_color_next = '0;
            end else begin
                out_vert_next  = job_idx_reg[0];
                out_done_next  = 1'b0;
                out_last_next  = (job_idx_reg == SPAN_IDX_LAST);
                out_fixed_next = span_fixed;
                out_start_next = span_start;
                out_end_next   = span_end;
                out_color_next = ring_color_reg;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_active_reg  <= 1'b0;
            job_idx_reg     <= SPAN_IDX_FIRST;
            out_valid_reg   <= 1'b0;
            center_col_reg  <= '0;
            center_row_reg  <= '0;
            outer_x_reg     <= '0;
            inner_x_reg     <= '0;
            inner_limit_reg <= '0;
            row_offset_reg  <= '0;
            outer_error_reg <= '0;
            inner_error_reg <= '0;
            ring_color_reg  <= '0;
        end else begin
            job_active_reg  <= job_active_next;
            job_idx_reg     <= job_idx_next;
            out_valid_reg   <= out_valid_next;
            center_col_reg  <= center_col_next;
            center_row_reg  <= center_row_next;
            outer_x_reg     <= outer_x_next;
            inner_x_reg     <= inner_x_next;
            inner_limit_reg <= inner_limit_next;
            row_offset_reg  <= row_offset_next;
            outer_error_reg <= outer_error_next;
            inner_error_reg <= inner_error_next;
            ring_color_reg  <= ring_color_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        out_vert_reg  <= out_vert_next;
        out_done_reg  <= out_done_next;
        out_last_reg  <= out_last_next;
        out_fixed_reg <= out_fixed_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_color_reg <= out_color_next;
    end

    // ports
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({out_color_reg, out_end_reg,
                                           out_start_reg, out_fixed_reg});
    always_comb begin
        m_axis_tuser                = '0;
        m_axis_tuser[OUT_USER_VERT] = out_vert_reg;
        m_axis_tuser[OUT_USER_DONE] = out_done_reg;
    end

    // checks
    a_ready_only_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tready && job_active_reg) |-> job_finish)
        else $error("input taken while a step is still emitting");

    a_job_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !ring_done && job_idx_reg != SPAN_IDX_LAST) |=> job_active_reg)
        else $error("step ended before its last span");

    a_last_is_vertical: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast && !out_done_reg) |-> out_vert_reg)
        else $error("last span of a row is not the vertical eighth span");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_done_reg) |-> (m_axis_tlast && !out_vert_reg))
        else $error("done item without last flag");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(m_axis_tvalid) && !$past(m_axis_tready)) |-> !$past(out_load))
        else $error("result register overwritten while stalled");

endmodule : thick_circle_span_generator

`default_nettype wire

// ----- tb/tcsg_tb_pkg.sv -----
// Span record and ring scoreboard used by the thick circle span generator testbench.
package tcsg_tb_pkg;
    import tcsg_pkg::*;

    // One span (or done marker) as it leaves the block
    typedef struct {
        bit               vertical;
        bit signed [13:0] fixed_coord;
        bit signed [13:0] span_start;
        bit signed [13:0] span_end;
        bit [23:0]        color;
        bit               last;
        bit               done;
    } span_t;

    // Tracks the ring state and keeps the spans still owed by the block
    class ring_scoreboard;
        bit [11:0]        center_col;
        bit [11:0]        center_row;
        int               outer_x;
        int               inner_x;
        int               inner_limit;
        int               row_offset;
        bit signed [13:0] outer_err;
        bit signed [13:0] inner_err;
        bit [23:0]        ring_color;
        span_t            expected_spans[$];
        int               errors;

        function new();
            center_col  = '0;
            center_row  = '0;
            outer_x     = 0;
            inner_x     = 0;
            inner_limit = 0;
            row_offset  = 0;
            outer_err   = '0;
            inner_err   = '0;
            ring_color  = '0;
            errors      = 0;
        endfunction

        function void push_span(bit vert, int fixed, int first_c, int last_c, bit is_last);
            span_t sp;
            sp.vertical    = vert;
            sp.fixed_coord = fixed[13:0];
            sp.span_start  = first_c[13:0];
            sp.span_end    = last_c[13:0];
            sp.color       = ring_color;
            sp.last        = is_last;
            sp.done        = 1'b0;
            expected_spans.push_back(sp);
        endfunction

        // Accepted input item: update the ring and queue the spans it causes
        function void note_input(mode_t mode, bit [11:0] cx, bit [11:0] cy,
                                 bit [10:0] ro, bit [10:0] ri, bit [23:0] col);
            span_t sp;
            int    c_x;
            int    c_y;
            int    x0;
            int    xi;
            int    y;
            if (mode == MODE_START) begin
                if (ri > ro) begin
                    ri = ro;
                end
                center_col  = cx;
                center_row  = cy;
                outer_x     = int'(ro);
                inner_x     = int'(ri);
                inner_limit = int'(ri);
                row_offset  = 0;
                outer_err   = 14'(1 - int'(ro));
                inner_err   = 14'(1 - int'(ri));
                ring_color  = col;
                return;
            end
            // finished ring: one done marker, all span fields zero
            if (outer_x < row_offset) begin
                sp.vertical    = 1'b0;
                sp.fixed_coord = '0;
                sp.span_start  = '0;
                sp.span_end    = '0;
                sp.color       = '0;
                sp.last        = 1'b1;
                sp.done        = 1'b1;
                expected_spans.push_back(sp);
                return;
            end
            c_x = int'(center_col);
            c_y = int'(center_row);
            x0  = outer_x;
            xi  = inner_x;
            y   = row_offset;
            // eight octant spans of this row
            push_span(1'b0, c_y + y, c_x + xi, c_x + x0, 1'b0);
            push_span(1'b1, c_x + y, c_y + xi, c_y + x0, 1'b0);
            push_span(1'b0, c_y + y, c_x - x0, c_x - xi, 1'b0);
            push_span(1'b1, c_x - y, c_y + xi, c_y + x0, 1'b0);
            push_span(1'b0, c_y - y, c_x - x0, c_x - xi, 1'b0);
            push_span(1'b1, c_x - y, c_y - x0, c_y - xi, 1'b0);
            push_span(1'b0, c_y - y, c_x + xi, c_x + x0, 1'b0);
            push_span(1'b1, c_x + y, c_y - x0, c_y - xi, 1'b1);
            // advance both midpoint errors by one row
            y++;
            if (outer_err < 0) begin
                outer_err = 14'(outer_err + 2 * y + 1);
            end else begin
                x0--;
                outer_err = 14'(outer_err + 2 * (y - x0 + 1));
            end
            // past the inner radius the inner edge tracks the row
            if (y > inner_limit) begin
                xi = y;
            end else if (inner_err < 0) begin
                inner_err = 14'(inner_err + 2 * y + 1);
            end else begin
                xi--;
                inner_err = 14'(inner_err + 2 * (y - xi + 1));
            end
            outer_x    = x0;
            inner_x    = xi;
            row_offset = y;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Accepted result item: compare with the oldest expected span
        task check_result(span_t got);
            span_t want;
            if (expected_spans.size() == 0) begin
                report($sformatf("unexpected item vert=%0d fixed=%0d start=%0d end=%0d done=%0d",
                                 got.vertical, got.fixed_coord, got.span_start,
                                 got.span_end, got.done));
                return;
            end
            want = expected_spans.pop_front();
            if (got.vertical != want.vertical)
                report($sformatf("span_vertical got %0d want %0d", got.vertical, want.vertical));
            if (got.fixed_coord != want.fixed_coord)
                report($sformatf("fixed_coord got %0d want %0d", got.fixed_coord,
                                 want.fixed_coord));
            if (got.span_start != want.span_start)
                report($sformatf("span_start got %0d want %0d", got.span_start,
                                 want.span_start));
            if (got.span_end != want.span_end)
                report($sformatf("span_end got %0d want %0d", got.span_end, want.span_end));
            if (got.color != want.color)
                report($sformatf("span_color got %h want %h", got.color, want.color));
            if (got.last != want.last)
                report($sformatf("last got %0d want %0d", got.last, want.last));
            if (got.done != want.done)
                report($sformatf("done_res got %0d want %0d", got.done, want.done));
        endtask

        function int pending();
            return expected_spans.size();
        endfunction

        task check_drained();
            if (expected_spans.size() != 0)
                report($sformatf("%0d expected items never arrived", expected_spans.size()));
        endtask
    endclass

endpackage : tcsg_tb_pkg

// ----- tb/tb_thick_circle_span_generator.sv -----
// Testbench top: drives rings and steps into the span generator and checks every span.
module tb_thick_circle_span_generator;
    import tcsg_pkg::*;
    import tcsg_tb_pkg::*;

    localparam int IN_DATA_BITS   = 72;
    localparam int OUT_DATA_BITS  = 72;
    localparam int CLK_PERIOD     = 20;
    localparam int DIRECTED_ITEMS = 21;
    localparam int RANDOM_ITEMS   = 150;
    localparam int CALM_ITEMS     = 30;
    localparam int DRAIN_CYCLES   = 24;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    // center_x, center_y, outer_radius, inner_radius, color, zero pad
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;
    // mode
    logic [0:0]               s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    // fixed_coord, span_start, span_end, span_color, zero pad
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    // span_vertical, done_res
    logic [OUT_USER_BITS-1:0] m_axis_tuser;
    logic                     m_axis_tlast;

    ring_scoreboard rings = new();
    bit             calm;
    int             items_sent;

    thick_circle_span_generator #(
        .COORD_BITS(12),
        .COLOR_BITS(24)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Watch both channels at the rising edge
    always @(posedge aclk) begin
        span_t got;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            rings.note_input(mode_t'(s_axis_tuser[0]), s_axis_tdata[11:0], s_axis_tdata[23:12],
                             s_axis_tdata[34:24], s_axis_tdata[45:35], s_axis_tdata[69:46]);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.vertical    = m_axis_tuser[OUT_USER_VERT];
            got.done        = m_axis_tuser[OUT_USER_DONE];
            got.fixed_coord = m_axis_tdata[13:0];
            got.span_start  = m_axis_tdata[27:14];
            got.span_end    = m_axis_tdata[41:28];
            got.color       = m_axis_tdata[65:42];
            got.last        = m_axis_tlast;
            rings.check_result(got);
        end
    end

    // Result side backpressure: random stall bursts, none once calm
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
            m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    // Present one item, with an optional idle burst ahead of it
    task automatic send_item(mode_t mode, bit [11:0] cx, bit [11:0] cy,
                             bit [10:0] ro, bit [10:0] ri, bit [23:0] col);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {2'b00, col, ri, ro, cy, cx};
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Step item; the geometry fields are ignored, so fill them with noise
    task automatic step_ring();
        send_item(MODE_STEP, 12'($urandom), 12'($urandom), 11'($urandom), 11'($urandom),
                  24'($urandom));
    endtask

    // Stimulus
    initial begin
        int        pick;
        int        steps;
        bit [10:0] ro;
        bit [10:0] ri;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        calm          = 1'b0;
        items_sent    = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // steps straight out of reset: zero-radius ring at the origin, then done
        step_ring();
        step_ring();
        // largest center and radii, full color
        send_item(MODE_START, 12'hFFF, 12'hFFF, 11'h7FF, 11'h7FF, 24'hFFFFFF);
        step_ring();
        step_ring();
        // inner radius above outer gets clamped; run the ring out
        send_item(MODE_START, 12'h000, 12'h000, 11'd3, 11'h7FF, 24'h000000);
        repeat (4) step_ring();
        // thin inner radius: inner edge passes and spans go empty
        send_item(MODE_START, 12'd100, 12'd2000, 11'd5, 11'd1, 24'h5A5A5A);
        repeat (6) step_ring();
        // point ring, then repeated done markers
        send_item(MODE_START, 12'hA5A, 12'h5A5, 11'd0, 11'd0, 24'hA5A5A5);
        repeat (3) step_ring();

        // random rings, mostly well-formed start-then-step runs
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            calm = (items_sent >= DIRECTED_ITEMS + RANDOM_ITEMS - CALM_ITEMS);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                send_item(mode_t'($urandom_range(0, 1)), 12'($urandom), 12'($urandom),
                          11'($urandom), 11'($urandom), 24'($urandom));
            end else begin
                ro = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                                 : 11'($urandom_range(0, 24));
                case ($urandom_range(0, 3))
                    0: ri = 11'($urandom);
                    1: ri = ro;
                    2: ri = '0;
                    default: ri = 11'($urandom_range(0, ro));
                endcase
                if (pick == 1) begin
                    // cut short before the ring finishes
                    steps = $urandom_range(0, 2);
                end else if (ro <= 24) begin
                    steps = (ro * 3) / 4 + $urandom_range(1, 3);
                end else begin
                    steps = $urandom_range(1, 6);
                end
                send_item(MODE_START, 12'($urandom), 12'($urandom), ro, ri, 24'($urandom));
                repeat (steps) step_ring();
            end
        end

        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (rings.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        rings.check_drained();
        if (rings.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule : tb_thick_circle_span_generator

// ----- files.f -----
src/tcsg_pkg.sv
src/thick_circle_span_generator.sv
tb/tcsg_tb_pkg.sv
tb/tb_thick_circle_span_generator.sv
